@@ rtl/sitad_pkg.sv @@
// Package for the signed integer to decimal ASCII core.
// Shared constants and the item struct passed between pipeline stages; no dependencies.
package sitad_pkg;

    localparam int unsigned ValueWidth = 32;
    localparam int unsigned NumDigits  = 10;
    localparam int unsigned DigitWidth = 4;
    localparam int unsigned CountWidth = $clog2(NumDigits + 1);
    localparam int unsigned IdxWidth   = $clog2(NumDigits);
    localparam int unsigned CharWidth  = 8;

    localparam logic [CharWidth-1:0] CharZero  = 8'd48;
    localparam logic [CharWidth-1:0] CharMinus = 8'd45;

    // floor(x / 10) == (x * DivMagic) >> DivShift for every 32-bit unsigned x
    localparam logic [ValueWidth-1:0] DivMagic = 32'hCCCC_CCCD;
    localparam int unsigned           DivShift = 35;

    typedef logic [NumDigits-1:0][DigitWidth-1:0] digit_vec_t;

    // Work item: sign, remaining magnitude, digits collected so far (LS digit ends at index 0)
    typedef struct packed {
        logic                  neg;
        logic [ValueWidth-1:0] mag;
        digit_vec_t            digits;
        logic [CountWidth-1:0] ndig;
    } item_t;

endpackage

@@ rtl/sitad_input_stage.sv @@
// Input register stage: splits the two's complement value into sign and magnitude.
// Depends on sitad_pkg.
module sitad_input_stage (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [sitad_pkg::ValueWidth-1:0] in_value,
    output logic                            out_valid,
    input  logic                            out_ready,
    output sitad_pkg::item_t                out_item
);
    import sitad_pkg::*;

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        item_next        = '0;
        item_next.neg    = in_value[ValueWidth-1];
        // 0 - x is exact for the most negative value in unsigned arithmetic
        item_next.mag    = in_value[ValueWidth-1] ? (ValueWidth'(0) - in_value) : in_value;
        item_next.digits = '0;
        item_next.ndig   = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

@@ rtl/sitad_digit_stage.sv @@
// One digit extraction stage: divides the magnitude by ten and shifts the remainder in.
// Depends on sitad_pkg.
module sitad_digit_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  sitad_pkg::item_t in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output sitad_pkg::item_t out_item
);
    import sitad_pkg::*;

    logic                      valid_reg;
    item_t                     item_reg;
    item_t                     item_next;
    logic [2*ValueWidth-1:0]   prod;
    logic [ValueWidth-1:0]     quot;
    logic [ValueWidth-1:0]     quot_x10;
    logic [ValueWidth-1:0]     rem_full;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        prod     = {{ValueWidth{1'b0}}, in_item.mag} * {{ValueWidth{1'b0}}, DivMagic};
        quot     = ValueWidth'(prod >> DivShift);
        quot_x10 = (quot << 3) + (quot << 1);
        rem_full = in_item.mag - quot_x10;

        item_next        = in_item;
        item_next.mag    = quot;
        item_next.digits = {rem_full[DigitWidth-1:0], in_item.digits[NumDigits-1:1]};
        // Count a digit while magnitude is non-zero; zero still gives one digit
        if ((in_item.mag != '0) || (in_item.ndig == '0)) begin
            item_next.ndig = in_item.ndig + CountWidth'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

@@ rtl/sitad_serializer.sv @@
// Output serialiser: holds one converted number and emits sign then digits, one per beat.
// Depends on sitad_pkg.
module sitad_serializer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  sitad_pkg::item_t                in_item,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [sitad_pkg::CharWidth-1:0] m_char_code,
    output logic                            m_last_char
);
    import sitad_pkg::*;

    logic                busy_reg;
    logic                busy_next;
    logic                sign_reg;
    logic                sign_next;
    logic [IdxWidth-1:0] idx_reg;
    logic [IdxWidth-1:0] idx_next;
    digit_vec_t          digits_reg;
    logic                beat_done;
    logic                run_done;
    logic                load;

    assign beat_done = busy_reg && m_ready;
    assign run_done  = beat_done && !sign_reg && (idx_reg == '0);
    assign in_ready  = !busy_reg || run_done;
    assign load      = in_ready && in_valid;

    always_comb begin
        busy_next = busy_reg;
        sign_next = sign_reg;
        idx_next  = idx_reg;
        if (load) begin
            busy_next = 1'b1;
            sign_next = in_item.neg;
            idx_next  = IdxWidth'(in_item.ndig - CountWidth'(1));
        end else if (run_done) begin
            busy_next = 1'b0;
        end else if (beat_done) begin
            if (sign_reg) begin
                sign_next = 1'b0;
            end else begin
                idx_next = idx_reg - IdxWidth'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            sign_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            sign_reg <= sign_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            digits_reg <= in_item.digits;
        end
    end

    always_comb begin
        if (sign_reg) begin
            m_char_code = CharMinus;
            m_last_char = 1'b0;
        end else begin
            m_char_code = CharZero + {{(CharWidth-DigitWidth){1'b0}}, digits_reg[idx_reg]};
            m_last_char = (idx_reg == '0);
        end
    end

    assign m_valid = busy_reg;

endmodule

@@ rtl/signed_int_to_decimal_ascii_core.sv @@
// Top level of the signed integer to decimal ASCII core.
// Depends on sitad_pkg, sitad_input_stage, sitad_digit_stage and sitad_serializer.
//
// Converts one signed 32-bit value per input beat into its decimal text, sent as one
// ASCII character per output beat, most significant digit first, with a leading '-'
// for negative values and m_last_char high on the final character. A value enters an
// eleven-register pipeline (sign/magnitude, then ten divide-by-ten stages) and is loaded
// into the output serialiser from the last stage, which then offers its first character.
// The pipeline takes a new value every cycle until it fills. Sustained rate is set by
// the serialiser, which emits one character per cycle while m_ready is high: a value
// gives it (digits + sign) characters, 1 to 11, and the next value follows with no gap
// when m_ready is held high.
module signed_int_to_decimal_ascii_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [sitad_pkg::ValueWidth-1:0] s_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [sitad_pkg::CharWidth-1:0] m_char_code,
    output logic                            m_last_char
);
    import sitad_pkg::*;

    logic  [NumDigits:0] stg_valid;
    logic  [NumDigits:0] stg_ready;
    item_t               stg_item [NumDigits+1];

    sitad_input_stage u_input (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_value  (s_value),
        .out_valid (stg_valid[0]),
        .out_ready (stg_ready[0]),
        .out_item  (stg_item[0])
    );

    for (genvar g = 0; g < NumDigits; g++) begin : g_digit
        sitad_digit_stage u_digit (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stg_valid[g]),
            .in_ready  (stg_ready[g]),
            .in_item   (stg_item[g]),
            .out_valid (stg_valid[g+1]),
            .out_ready (stg_ready[g+1]),
            .out_item  (stg_item[g+1])
        );
    end

    sitad_serializer u_ser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (stg_valid[NumDigits]),
        .in_ready    (stg_ready[NumDigits]),
        .in_item     (stg_item[NumDigits]),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char_code (m_char_code),
        .m_last_char (m_last_char)
    );

endmodule

@@ bench/sitad_checker.sv @@
// Checker for the signed integer to decimal ASCII core: watches both channels,
// predicts the character run for each value taken in and compares it beat by beat.
// Depends on sitad_pkg for widths and character constants.
`timescale 1ns / 100ps

module sitad_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [sitad_pkg::ValueWidth-1:0] s_value,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [sitad_pkg::CharWidth-1:0] m_char_code,
    input  logic                            m_last_char,
    output int                              fail_count,
    output int                              chars_pending
);
    import sitad_pkg::*;

    localparam logic [ValueWidth-1:0] DecimalBase = 32'd10;

    typedef struct {
        logic [CharWidth-1:0] code;
        logic                 last;
    } text_char_t;

    text_char_t expected_chars[$];
    text_char_t oldest;
    int         mismatches = 0;

    assign fail_count = mismatches;

    // Text of one value: optional sign, then digits most significant first
    function automatic void predict_decimal_text(input logic [ValueWidth-1:0] raw);
        logic [ValueWidth-1:0] magnitude;
        logic [DigitWidth-1:0] digit_buf [NumDigits];
        int                    ndigits;
        text_char_t            c;
        // negate in unsigned arithmetic so the most negative value is exact
        magnitude = raw[ValueWidth-1] ? (~raw + 1'b1) : raw;
        ndigits   = 0;
        do begin
            digit_buf[ndigits] = DigitWidth'(magnitude % DecimalBase);
            ndigits++;
            magnitude = magnitude / DecimalBase;
        end while (magnitude != 0);
        if (raw[ValueWidth-1]) begin
            c.code = CharMinus;
            c.last = 1'b0;
            expected_chars.push_back(c);
        end
        for (int k = ndigits - 1; k >= 0; k--) begin
            c.code = CharZero + CharWidth'(digit_buf[k]);
            c.last = (k == 0);
            expected_chars.push_back(c);
        end
    endfunction

    initial chars_pending = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_chars.size() == 0) begin
                    $error("unexpected char beat: char_code %0d last_char %0b",
                           m_char_code, m_last_char);
                    mismatches++;
                end else begin
                    oldest = expected_chars.pop_front();
                    if (m_char_code !== oldest.code) begin
                        $error("char_code: expected %0d, got %0d", oldest.code, m_char_code);
                        mismatches++;
                    end
                    if (m_last_char !== oldest.last) begin
                        $error("last_char: expected %0b, got %0b", oldest.last, m_last_char);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready)
                predict_decimal_text(s_value);
        end
        chars_pending = expected_chars.size();
    end

endmodule

@@ bench/testbench.sv @@
// Top of the bench for signed_int_to_decimal_ascii_core: clock, reset, value stimulus,
// random back-pressure and the verdict. Depends on sitad_pkg, the core and sitad_checker.
`timescale 1ns / 100ps

module testbench;
    import sitad_pkg::*;

    localparam int IdleLimit   = 2000;
    localparam int DrainCycles = 30;
    localparam int RandomItems = 400;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [ValueWidth-1:0] s_value;
    logic                  m_valid;
    logic                  m_ready;
    logic [CharWidth-1:0]  m_char_code;
    logic                  m_last_char;

    int fail_count;
    int chars_pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    always #5 aclk = ~aclk;

    signed_int_to_decimal_ascii_core i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char_code (m_char_code),
        .m_last_char (m_last_char)
    );

    sitad_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_char_code   (m_char_code),
        .m_last_char   (m_last_char),
        .fail_count    (fail_count),
        .chars_pending (chars_pending)
    );

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    // Watchdog: cycles with no beat on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IdleLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat
    task automatic send_value(input logic [ValueWidth-1:0] v);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Mostly values of a chosen digit count, so short and long runs are even
    function automatic logic [ValueWidth-1:0] random_value();
        longint lo;
        longint hi;
        longint magnitude;
        int     ndigits;
        bit     neg;
        if ($urandom_range(3, 0) == 0)
            return $urandom();
        ndigits = $urandom_range(10, 1);
        neg     = ($urandom_range(1, 0) != 0);
        lo      = (ndigits == 1) ? 0 : longint'(10) ** (ndigits - 1);
        hi      = (longint'(10) ** ndigits) - 1;
        if (ndigits == 10)
            hi = neg ? 64'd2147483648 : 64'd2147483647;
        magnitude = lo + longint'($urandom_range(32'(hi - lo), 0));
        return neg ? ValueWidth'(-magnitude) : ValueWidth'(magnitude);
    endfunction

    logic [ValueWidth-1:0] directed_values[] = '{
        32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99, 32'd100,
        32'd7, -32'sd100, 32'd999999999, 32'd1000000000, -32'sd1000000000,
        32'd1234567890, -32'sd1234567890, 32'h7FFF_FFFF, 32'h7FFF_FFFE,
        32'h8000_0000, 32'h8000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'd1000000
    };

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_value = '0;
        m_ready = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_values[i])
            send_value(directed_values[i]);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            repeat (RandomItems / 4)
                send_value(random_value());
        end
        s_valid <= 1'b0;
        recv_stall_pct = 0;

        while (chars_pending != 0)
            @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/sitad_pkg.sv
rtl/sitad_input_stage.sv
rtl/sitad_digit_stage.sv
rtl/sitad_serializer.sv
rtl/signed_int_to_decimal_ascii_core.sv
bench/sitad_checker.sv
bench/testbench.sv
